// ----- sv/normal_map_texel_validator_top_defines.svh -----
// Assertion macros for the normal map texel validator.
// Included by modules that carry concurrent assertions; needs no package.
`ifndef NORMAL_MAP_TEXEL_VALIDATOR_TOP_DEFINES_SVH
`define NORMAL_MAP_TEXEL_VALIDATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NMTV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("normal map texel validator: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NMTV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("normal map texel validator: assertion failed");

`endif

// ----- sv/nmtv_pkg.sv -----
// Shared types, constants and decode function of the normal map texel validator.
// Has no dependencies.
`default_nettype none

package nmtv_pkg;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 112;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;
	localparam int SQ_W       = 18;
	localparam int CNT_W      = 12;
	localparam int WID_W      = 13;
	localparam int SUM_W      = 33;
	localparam int COMP_W     = 9;
	localparam int CNT_LIMIT  = 4096;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN_SQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN_SQ = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 2'd2;

	localparam logic [SQ_W-1:0]  MIN_LEN_SQ_RST = 18'd0;
	localparam logic [SQ_W-1:0]  MAX_LEN_SQ_RST = 18'd195075;
	localparam logic [WID_W-1:0] IMG_WIDTH_RST  = 13'd4096;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 33'sh0_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 33'sh1_0000_0000;

	typedef struct packed {
		logic [SQ_W-1:0]          sq;
		logic signed [COMP_W-1:0] sx;
		logic signed [COMP_W-1:0] sy;
		logic                     neg_z;
		logic                     frame_start;
	} stage_t;

	function automatic logic signed [COMP_W-1:0] decode(input logic [7:0] c);
		logic signed [COMP_W:0] t;
		t = $signed({1'b0, c, 1'b0}) - 10'sd255;
		return t[COMP_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- sv/normal_map_texel_validator_top.sv -----
// Normal map texel validator, top level and only module.
// Depends on nmtv_pkg and normal_map_texel_validator_top_defines.svh.
`default_nettype none
`include "normal_map_texel_validator_top_defines.svh"

// Takes one texel per transaction and returns one result per texel, one transaction per
// clock when the output side keeps up. The texel passes a decode stage that forms the
// squared length, then the result register where the thresholds are compared and the
// column, row and saturating bias sums advance. A configuration write takes effect
// at the next clock edge, so registers must be written only while no texel is in flight.
module normal_map_texel_validator_top #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [nmtv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [nmtv_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// red [7:0], green [15:8], blue [23:16]
	input  wire  [nmtv_pkg::IN_DATA_W-1:0]       s_tdata,
	// frame_start
	input  wire                                  s_tuser,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	// bad_length [0], bad_direction [1], squared_length [19:2], column [31:20],
	// row [43:32], bias_x [76:44], bias_y [109:77], zero fill [111:110]
	output logic [nmtv_pkg::OUT_DATA_W-1:0]      m_tdata
);

	localparam int W_LIM    = (MAX_WIDTH < nmtv_pkg::CNT_LIMIT) ? MAX_WIDTH
		: nmtv_pkg::CNT_LIMIT;
	localparam int H_LIM    = (MAX_HEIGHT < nmtv_pkg::CNT_LIMIT) ? MAX_HEIGHT
		: nmtv_pkg::CNT_LIMIT;
	localparam logic [nmtv_pkg::WID_W-1:0] W_LIM_V    = nmtv_pkg::WID_W'(W_LIM);
	localparam logic [nmtv_pkg::CNT_W-1:0] LAST_ROW_V = nmtv_pkg::CNT_W'(H_LIM - 1);

	logic [nmtv_pkg::SQ_W-1:0]  min_len_sq_q;
	logic [nmtv_pkg::SQ_W-1:0]  max_len_sq_q;
	logic [nmtv_pkg::WID_W-1:0] img_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_sq_q <= nmtv_pkg::MIN_LEN_SQ_RST;
			max_len_sq_q <= nmtv_pkg::MAX_LEN_SQ_RST;
			img_width_q  <= nmtv_pkg::IMG_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				nmtv_pkg::REG_MIN_LEN_SQ: min_len_sq_q <= cfg_data;
				nmtv_pkg::REG_MAX_LEN_SQ: max_len_sq_q <= cfg_data;
				nmtv_pkg::REG_IMG_WIDTH:  img_width_q  <= cfg_data[nmtv_pkg::WID_W-1:0];
				default: ;
			endcase
		end
	end

	// Flow control.
	logic valid_s1;
	logic advance;
	logic in_acc;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_acc   = s_tvalid && s_tready;

	// Decode stage.
	logic signed [nmtv_pkg::COMP_W-1:0]   dx, dy, dz;
	logic signed [2*nmtv_pkg::COMP_W-1:0] px, py, pz;
	nmtv_pkg::stage_t                     dec, st_s1;

	always_comb begin
		dx = nmtv_pkg::decode(s_tdata[7:0]);
		dy = nmtv_pkg::decode(s_tdata[15:8]);
		dz = nmtv_pkg::decode(s_tdata[23:16]);
		px = dx * dx;
		py = dy * dy;
		pz = dz * dz;
		dec.sq = nmtv_pkg::SQ_W'({2'b00, px[15:0]}) + nmtv_pkg::SQ_W'({2'b00, py[15:0]})
			+ nmtv_pkg::SQ_W'({2'b00, pz[15:0]});
		dec.sx          = dx;
		dec.sy          = dy;
		dec.neg_z       = dz[nmtv_pkg::COMP_W-1];
		dec.frame_start = s_tuser;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_s1 <= dec;
		end
	end

	// Result stage: position and bias.
	logic [nmtv_pkg::CNT_W-1:0]         col_q, row_q;
	logic signed [nmtv_pkg::SUM_W-1:0]  sum_x_q, sum_y_q;
	logic [nmtv_pkg::WID_W-1:0]         w_eff;
	logic [nmtv_pkg::CNT_W-1:0]         c0, r0, c1, r1;
	logic [nmtv_pkg::WID_W-1:0]         c_inc;
	logic signed [nmtv_pkg::SUM_W-1:0]  bx0, by0, bx1, by1;
	logic signed [nmtv_pkg::SUM_W:0]    tx, ty;
	logic                               bad_len;

	always_comb begin
		w_eff = img_width_q;
		if (w_eff == '0) begin
			w_eff = nmtv_pkg::WID_W'(1);
		end
		if (w_eff > W_LIM_V) begin
			w_eff = W_LIM_V;
		end
		c0  = st_s1.frame_start ? '0 : col_q;
		r0  = st_s1.frame_start ? '0 : row_q;
		bx0 = st_s1.frame_start ? '0 : sum_x_q;
		by0 = st_s1.frame_start ? '0 : sum_y_q;
		c1  = ({1'b0, c0} >= w_eff) ? nmtv_pkg::CNT_W'(w_eff - 1'b1) : c0;
		r1  = (r0 > LAST_ROW_V) ? LAST_ROW_V : r0;
		c_inc = {1'b0, c1} + 1'b1;
		tx = {bx0[nmtv_pkg::SUM_W-1], bx0} + (nmtv_pkg::SUM_W+1)'(st_s1.sx);
		ty = {by0[nmtv_pkg::SUM_W-1], by0} + (nmtv_pkg::SUM_W+1)'(st_s1.sy);
		if (tx[nmtv_pkg::SUM_W] != tx[nmtv_pkg::SUM_W-1]) begin
			bx1 = tx[nmtv_pkg::SUM_W] ? nmtv_pkg::SUM_MIN : nmtv_pkg::SUM_MAX;
		end else begin
			bx1 = tx[nmtv_pkg::SUM_W-1:0];
		end
		if (ty[nmtv_pkg::SUM_W] != ty[nmtv_pkg::SUM_W-1]) begin
			by1 = ty[nmtv_pkg::SUM_W] ? nmtv_pkg::SUM_MIN : nmtv_pkg::SUM_MAX;
		end else begin
			by1 = ty[nmtv_pkg::SUM_W-1:0];
		end
		bad_len = (st_s1.sq < min_len_sq_q) || (st_s1.sq > max_len_sq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (advance) begin
				sum_x_q <= bx1;
				sum_y_q <= by1;
				if (c_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (r1 < LAST_ROW_V) ? r1 + 1'b1 : r1;
				end else begin
					col_q <= c_inc[nmtv_pkg::CNT_W-1:0];
					row_q <= r1;
				end
			end
			if (advance) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata <= {2'b00, by1, bx1, r1, c1, st_s1.sq, st_s1.neg_z, bad_len};
		end
	end

	`NMTV_ASSERT_SAME(a_stall_means_full, clk, arst_n, !s_tready, valid_s1 && m_tvalid)
	`NMTV_ASSERT_NEXT(a_advance_fills_out, clk, arst_n, advance, m_tvalid)
	`NMTV_ASSERT_SAME(a_row_in_range, clk, arst_n, m_tvalid, m_tdata[43:32] <= LAST_ROW_V)
	`NMTV_ASSERT_SAME(a_col_in_width, clk, arst_n, m_tvalid, {1'b0, m_tdata[31:20]} < w_eff)

endmodule

`default_nettype wire

// ----- tb/tb_normal_map_texel_validator_top.sv -----
// Testbench for the normal map texel validator: directed and random texel streams,
// checked against a behavioral predictor of decode, thresholds, position and bias sums.
// Depends on nmtv_pkg and normal_map_texel_validator_top.
`timescale 1ns / 1ps

module tb_normal_map_texel_validator_top;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int FULL_LEN_SQ = 195075;
	localparam longint BIAS_CEIL  = 64'sd4294967295;
	localparam longint BIAS_FLOOR = -64'sd4294967296;

	typedef struct packed {
		logic                               bad_length;
		logic                               bad_direction;
		logic [nmtv_pkg::SQ_W-1:0]          squared_length;
		logic [nmtv_pkg::CNT_W-1:0]         column;
		logic [nmtv_pkg::CNT_W-1:0]         row;
		logic signed [nmtv_pkg::SUM_W-1:0]  bias_x;
		logic signed [nmtv_pkg::SUM_W-1:0]  bias_y;
	} texel_result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [nmtv_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [nmtv_pkg::CFG_DATA_W-1:0]    cfg_data;
	logic                               s_tvalid;
	logic                               s_tready;
	logic [nmtv_pkg::IN_DATA_W-1:0]     s_tdata;
	logic                               s_tuser;
	logic                               m_tvalid;
	logic                               m_tready;
	logic [nmtv_pkg::OUT_DATA_W-1:0]    m_tdata;

	texel_result_t expected_texels[$];
	int unsigned   mismatch_count;
	int unsigned   src_idle_pct;
	int unsigned   sink_idle_pct;

	int     min_len_sq;
	int     max_len_sq;
	int     image_width;
	int     next_column;
	int     next_row;
	longint bias_sum_x;
	longint bias_sum_y;

	normal_map_texel_validator_top #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic longint clamp_bias(longint value);
		if (value > BIAS_CEIL) begin
			return BIAS_CEIL;
		end
		if (value < BIAS_FLOOR) begin
			return BIAS_FLOOR;
		end
		return value;
	endfunction

	function automatic texel_result_t predict_texel(logic [7:0] red, logic [7:0] green,
			logic [7:0] blue, logic frame_start);
		int sx;
		int sy;
		int sz;
		int sq;
		int eff_width;
		int last_row;
		texel_result_t res;
		sx = 2 * int'(red) - 255;
		sy = 2 * int'(green) - 255;
		sz = 2 * int'(blue) - 255;
		sq = sx * sx + sy * sy + sz * sz;
		eff_width = image_width;
		if (eff_width == 0) begin
			eff_width = 1;
		end
		if (eff_width > MAX_WIDTH) begin
			eff_width = MAX_WIDTH;
		end
		if (eff_width > nmtv_pkg::CNT_LIMIT) begin
			eff_width = nmtv_pkg::CNT_LIMIT;
		end
		last_row = (MAX_HEIGHT < nmtv_pkg::CNT_LIMIT) ? MAX_HEIGHT - 1
			: nmtv_pkg::CNT_LIMIT - 1;
		if (frame_start) begin
			next_column = 0;
			next_row = 0;
			bias_sum_x = 0;
			bias_sum_y = 0;
		end
		if (next_column >= eff_width) begin
			next_column = eff_width - 1;
		end
		if (next_row > last_row) begin
			next_row = last_row;
		end
		res.column = next_column[nmtv_pkg::CNT_W-1:0];
		res.row = next_row[nmtv_pkg::CNT_W-1:0];
		bias_sum_x = clamp_bias(bias_sum_x + sx);
		bias_sum_y = clamp_bias(bias_sum_y + sy);
		if (next_column + 1 >= eff_width) begin
			next_column = 0;
			if (next_row < last_row) begin
				next_row++;
			end
		end else begin
			next_column++;
		end
		res.bad_length = (sq < min_len_sq) || (sq > max_len_sq);
		res.bad_direction = (sz < 0);
		res.squared_length = sq[nmtv_pkg::SQ_W-1:0];
		res.bias_x = bias_sum_x[nmtv_pkg::SUM_W-1:0];
		res.bias_y = bias_sum_y[nmtv_pkg::SUM_W-1:0];
		return res;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127 + 8'($urandom_range(1));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_texel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
			logic frame_start);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {blue, green, red};
		s_tuser <= frame_start;
		do @(posedge clk); while (!s_tready);
		expected_texels.push_back(predict_texel(red, green, blue, frame_start));
	endtask

	task automatic write_register(logic [nmtv_pkg::CFG_IDX_W-1:0] index,
			logic [nmtv_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_texels.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			nmtv_pkg::REG_MIN_LEN_SQ: min_len_sq = int'(value);
			nmtv_pkg::REG_MAX_LEN_SQ: max_len_sq = int'(value);
			nmtv_pkg::REG_IMG_WIDTH: image_width = int'(value[nmtv_pkg::WID_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic test_decode_extremes();
		send_texel(8'd0, 8'd0, 8'd0, 1'b1);
		send_texel(8'd255, 8'd255, 8'd255, 1'b0);
		send_texel(8'd128, 8'd128, 8'd128, 1'b0);
		send_texel(8'd127, 8'd127, 8'd127, 1'b0);
		send_texel(8'd0, 8'd255, 8'd127, 1'b0);
		send_texel(8'd255, 8'd0, 8'd128, 1'b0);
	endtask

	task automatic test_thresholds();
		write_register(nmtv_pkg::REG_MIN_LEN_SQ, 18'd3);
		write_register(nmtv_pkg::REG_MAX_LEN_SQ, 18'd195074);
		send_texel(8'd128, 8'd128, 8'd128, 1'b1);
		send_texel(8'd127, 8'd128, 8'd129, 1'b0);
		send_texel(8'd0, 8'd0, 8'd0, 1'b0);
		write_register(nmtv_pkg::REG_MIN_LEN_SQ, 18'd4);
		send_texel(8'd128, 8'd128, 8'd128, 1'b0);
		write_register(nmtv_pkg::REG_MIN_LEN_SQ, 18'd195075);
		write_register(nmtv_pkg::REG_MAX_LEN_SQ, 18'd3);
		send_texel(8'd128, 8'd128, 8'd128, 1'b0);
		send_texel(8'd0, 8'd0, 8'd0, 1'b0);
		write_register(nmtv_pkg::REG_MIN_LEN_SQ, 18'd0);
		write_register(nmtv_pkg::REG_MAX_LEN_SQ, 18'd0);
		send_texel(8'd128, 8'd128, 8'd128, 1'b0);
		write_register(nmtv_pkg::REG_MAX_LEN_SQ, 18'(FULL_LEN_SQ));
	endtask

	task automatic test_frame_and_width();
		write_register(nmtv_pkg::REG_IMG_WIDTH, 18'h3E003);
		send_texel(8'd200, 8'd10, 8'd250, 1'b1);
		repeat (4) send_texel(pick_byte(), pick_byte(), pick_byte(), 1'b0);
		send_texel(8'd30, 8'd220, 8'd140, 1'b1);
		send_texel(pick_byte(), pick_byte(), pick_byte(), 1'b0);
		write_register(nmtv_pkg::REG_IMG_WIDTH, 18'd0);
		repeat (2) send_texel(pick_byte(), pick_byte(), pick_byte(), 1'b0);
		write_register(nmtv_pkg::REG_IMG_WIDTH, 18'd8);
		send_texel(pick_byte(), pick_byte(), pick_byte(), 1'b1);
		repeat (5) send_texel(pick_byte(), pick_byte(), pick_byte(), 1'b0);
		write_register(nmtv_pkg::REG_IMG_WIDTH, 18'd3);
		repeat (2) send_texel(pick_byte(), pick_byte(), pick_byte(), 1'b0);
	endtask

	task automatic test_long_stream(logic [nmtv_pkg::CFG_DATA_W-1:0] width_value,
			int unsigned texel_count);
		write_register(nmtv_pkg::REG_IMG_WIDTH, width_value);
		send_texel(pick_byte(), pick_byte(), pick_byte(), 1'b1);
		repeat (texel_count) send_texel(pick_byte(), pick_byte(), pick_byte(), 1'b0);
	endtask

	task automatic test_random_frames(int unsigned texel_budget);
		int unsigned sent;
		int unsigned frame_len;
		logic [nmtv_pkg::CFG_DATA_W-1:0] lo;
		logic [nmtv_pkg::CFG_DATA_W-1:0] hi;
		logic start_flag;
		sent = 0;
		while (sent < texel_budget) begin
			lo = 18'($urandom_range(FULL_LEN_SQ));
			case ($urandom_range(3))
				0: begin
					lo = 18'd0;
					hi = 18'(FULL_LEN_SQ);
				end
				1: hi = 18'($urandom_range(FULL_LEN_SQ, lo));
				2: hi = 18'($urandom_range(FULL_LEN_SQ));
				default: hi = lo;
			endcase
			write_register(nmtv_pkg::REG_MIN_LEN_SQ, lo);
			write_register(nmtv_pkg::REG_MAX_LEN_SQ, hi);
			if ($urandom_range(9) == 0) begin
				write_register(nmtv_pkg::REG_IMG_WIDTH, 18'($urandom_range(8191)));
			end else begin
				write_register(nmtv_pkg::REG_IMG_WIDTH, 18'($urandom_range(8, 1)));
			end
			repeat ($urandom_range(4, 1)) begin
				frame_len = $urandom_range(40, 1);
				for (int unsigned k = 0; k < frame_len; k++) begin
					start_flag = (k == 0);
					if ($urandom_range(19) == 0) begin
						start_flag = ~start_flag;
					end
					send_texel(pick_byte(), pick_byte(), pick_byte(), start_flag);
					sent++;
				end
			end
		end
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		texel_result_t got;
		texel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.bad_length = m_tdata[0];
			got.bad_direction = m_tdata[1];
			got.squared_length = m_tdata[19:2];
			got.column = m_tdata[31:20];
			got.row = m_tdata[43:32];
			got.bias_x = m_tdata[76:44];
			got.bias_y = m_tdata[109:77];
			if (expected_texels.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with none expected: sq=%0d col=%0d row=%0d",
					$realtime, got.squared_length, got.column, got.row);
			end else begin
				want = expected_texels.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: expected bl=%0b bd=%0b sq=%0d col=%0d row=%0d bx=%0d by=%0d",
						$realtime, want.bad_length, want.bad_direction,
						want.squared_length, want.column, want.row,
						want.bias_x, want.bias_y);
					$display("%0t: actual   bl=%0b bd=%0b sq=%0d col=%0d row=%0d bx=%0d by=%0d",
						$realtime, got.bad_length, got.bad_direction,
						got.squared_length, got.column, got.row,
						got.bias_x, got.bias_y);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("[normal_map_texel_validator_top] ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		mismatch_count = 0;
		min_len_sq = int'(nmtv_pkg::MIN_LEN_SQ_RST);
		max_len_sq = int'(nmtv_pkg::MAX_LEN_SQ_RST);
		image_width = int'(nmtv_pkg::IMG_WIDTH_RST);
		next_column = 0;
		next_row = 0;
		bias_sum_x = 0;
		bias_sum_y = 0;
		src_idle_pct = 8;
		sink_idle_pct = 45;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_decode_extremes();
		test_thresholds();
		test_frame_and_width();
		test_long_stream(18'd1, 250);
		test_long_stream(18'd8191, 250);
		test_random_frames(330);

		src_idle_pct = 45;
		sink_idle_pct = 8;
		test_random_frames(330);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_frames(330);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_texels.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_texels.size() == 0) begin
			$display("[normal_map_texel_validator_top] OK");
		end else begin
			$display("[normal_map_texel_validator_top] ERROR");
		end
		$finish;
	end

endmodule
